### design/stc_pkg.sv
// Shared types, constants and the month length table of the seconds-to-calendar converter.
package stc_pkg;

  localparam int unsigned AluW = 18;

  typedef logic [AluW-1:0] alu_t;

  localparam alu_t SecsPerDay  = alu_t'(86400);
  localparam alu_t SecsPerHour = alu_t'(3600);
  localparam alu_t SecsPerMin  = alu_t'(60);

  localparam logic [11:0] EpochYear   = 12'd2025;
  localparam logic [1:0]  EpochMod4   = 2'd1;
  localparam logic [6:0]  EpochMod100 = 7'd25;
  localparam logic [8:0]  EpochMod400 = 9'd25;

  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  function automatic logic [8:0] month_length(input logic [3:0] month, input logic leap);
    logic [8:0] d;
    unique case (month)
      4'd2:                      d = leap ? 9'd29 : 9'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 9'd30;
      default:                   d = 9'd31;
    endcase
    return d;
  endfunction

endpackage

### design/stc_alu.sv
// Shared compare-and-subtract unit used by every step of the conversion.
module stc_alu (
  input  stc_pkg::alu_t a_i,
  input  stc_pkg::alu_t b_i,
  output stc_pkg::alu_t diff_o,
  output logic          ge_o
);
  import stc_pkg::*;

  logic [AluW:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[AluW-1:0];
  assign ge_o   = ~full[AluW];

endmodule

### design/seconds_to_calendar_datetime_core.sv
// Top level: sequencer that converts elapsed seconds into a calendar date and time.
// Steps: day division, hour division and minute division, then the years and after them the
// months are counted off one at a time until the remaining days no longer cover one. Busy
// drops in the strobe cycle, so a new transaction is accepted only once the previous result
// has been given. The result strobe cannot be stalled.
// Reset clears the sequencer to idle; the result registers are not reset.
module seconds_to_calendar_datetime_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] elapsed_seconds_i,
  output logic        result_valid_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);
  import stc_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StDays,
    StHours,
    StMins,
    StYears,
    StMonths
  } state_e;

  state_e      state_q;
  logic        valid_q;
  logic [4:0]  cnt_q;
  logic [16:0] acc_q;
  logic [31:0] shreg_q;
  logic [15:0] days_q;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [1:0]  m4_q;
  logic [6:0]  m100_q;
  logic [8:0]  m400_q;

  logic        leap;
  alu_t        alu_a;
  alu_t        alu_b;
  alu_t        alu_diff;
  logic        alu_ge;
  alu_t        trial;
  logic [16:0] step_acc;
  logic [31:0] step_sh;
  logic        month_step;

  assign leap  = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
  assign trial = {acc_q, shreg_q[31]};

  always_comb begin
    unique case (state_q)
      StDays:   alu_b = SecsPerDay;
      StHours:  alu_b = SecsPerHour;
      StMins:   alu_b = SecsPerMin;
      StYears:  alu_b = leap ? alu_t'(366) : alu_t'(365);
      default:  alu_b = alu_t'(month_length(month_q, leap));
    endcase
    if ((state_q == StYears) || (state_q == StMonths)) begin
      alu_a = {2'b00, days_q};
    end else begin
      alu_a = trial;
    end
  end

  stc_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  assign step_acc   = alu_ge ? alu_diff[16:0] : trial[16:0];
  assign step_sh    = {shreg_q[30:0], alu_ge};
  assign month_step = alu_ge && (month_q != MonthDec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= (state_q == StMonths) && !month_step;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            state_q  <= StDays;
            cnt_q    <= 5'd31;
            acc_q    <= '0;
            shreg_q  <= elapsed_seconds_i;
            year_q   <= EpochYear;
            month_q  <= 4'd1;
            m4_q     <= EpochMod4;
            m100_q   <= EpochMod100;
            m400_q   <= EpochMod400;
          end
        end
        StDays: begin
          if (cnt_q == 5'd0) begin
            days_q  <= step_sh[15:0];
            acc_q   <= '0;
            shreg_q <= {step_acc, 15'd0};
            cnt_q   <= 5'd16;
            state_q <= StHours;
          end else begin
            cnt_q   <= cnt_q - 5'd1;
            acc_q   <= step_acc;
            shreg_q <= step_sh;
          end
        end
        StHours: begin
          if (cnt_q == 5'd0) begin
            hour_q  <= step_sh[4:0];
            acc_q   <= '0;
            shreg_q <= {step_acc[11:0], 20'd0};
            cnt_q   <= 5'd11;
            state_q <= StMins;
          end else begin
            cnt_q   <= cnt_q - 5'd1;
            acc_q   <= step_acc;
            shreg_q <= step_sh;
          end
        end
        StMins: begin
          if (cnt_q == 5'd0) begin
            minute_q <= step_sh[5:0];
            second_q <= step_acc[5:0];
            state_q  <= StYears;
          end else begin
            cnt_q   <= cnt_q - 5'd1;
            acc_q   <= step_acc;
            shreg_q <= step_sh;
          end
        end
        StYears: begin
          if (alu_ge) begin
            days_q <= alu_diff[15:0];
            year_q <= year_q + 12'd1;
            m4_q   <= m4_q + 2'd1;
            m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
            m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
          end else begin
            state_q <= StMonths;
          end
        end
        StMonths: begin
          if (month_step) begin
            days_q  <= alu_diff[15:0];
            month_q <= month_q + 4'd1;
          end else begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;
  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = days_q[4:0] + 5'd1;
  assign hour_o         = hour_q;
  assign minute_o       = minute_q;
  assign second_o       = second_q;

endmodule

### bench/seconds_to_calendar_datetime_checker.sv
// Checker that predicts the calendar date and time of each transaction and compares the results.
module seconds_to_calendar_datetime_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] elapsed_seconds_i,
  input  logic        result_valid_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned DaySecs  = 86400;
  localparam int unsigned HourSecs = 3600;
  localparam int unsigned MinSecs  = 60;
  localparam int unsigned FirstYear = 2025;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  calendar_t calendar_q[$];
  calendar_t want;
  int        mismatches;

  function automatic bit is_leap(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic calendar_t to_calendar(logic [31:0] secs);
    int unsigned days;
    int unsigned rem;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    calendar_t   c;
    days     = secs / DaySecs;
    rem      = secs % DaySecs;
    c.hour   = 5'(rem / HourSecs);
    rem      = rem % HourSecs;
    c.minute = 6'(rem / MinSecs);
    c.second = 6'(rem % MinSecs);
    yr = FirstYear;
    span = is_leap(yr) ? 366 : 365;
    while (days >= span) begin
      days -= span;
      yr++;
      span = is_leap(yr) ? 366 : 365;
    end
    mon = 1;
    forever begin
      case (mon)
        stc_pkg::MonthFeb: span = is_leap(yr) ? 29 : 28;
        4, 6, 9, 11:       span = 30;
        default:           span = 31;
      endcase
      if (days < span || mon >= stc_pkg::MonthDec) break;
      days -= span;
      mon++;
    end
    c.year  = 12'(yr);
    c.month = 4'(mon);
    c.day   = 5'(days + 1);
    return c;
  endfunction

  function automatic int field_differs(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calendar_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      mismatches = 0;
      if (result_valid_i) begin
        if (calendar_q.size() == 0) begin
          $error("Result with no transaction outstanding: %0d-%0d-%0d %0d:%0d:%0d",
                 year_i, month_i, day_of_month_i, hour_i, minute_i, second_i);
          mismatches = 1;
        end else begin
          want = calendar_q.pop_front();
          mismatches += field_differs("year", want.year, year_i);
          mismatches += field_differs("month", want.month, month_i);
          mismatches += field_differs("day_of_month", want.day, day_of_month_i);
          mismatches += field_differs("hour", want.hour, hour_i);
          mismatches += field_differs("minute", want.minute, minute_i);
          mismatches += field_differs("second", want.second, second_i);
        end
      end
      if (start_i && !busy_i) begin
        calendar_q.push_back(to_calendar(elapsed_seconds_i));
      end
      fail_count_o <= fail_count_o + mismatches;
      pending_o    <= calendar_q.size();
    end
  end

endmodule

### bench/seconds_to_calendar_datetime_core_tb.sv
// Testbench top: drives second counts into the converter and reports the verdict.
module seconds_to_calendar_datetime_core_tb;

  localparam int RandomCount = 1850;
  localparam int CycleLimit  = 3000000;
  localparam int DrainCycles = 250;
  localparam int LastDay     = 49709;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] elapsed_seconds_i;
  logic        result_valid_o;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;
  int          fail_count;
  int          pending;
  int          cycle_cnt = 0;

  seconds_to_calendar_datetime_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .elapsed_seconds_i (elapsed_seconds_i),
    .result_valid_o    (result_valid_o),
    .year_o            (year_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o),
    .hour_o            (hour_o),
    .minute_o          (minute_o),
    .second_o          (second_o)
  );

  seconds_to_calendar_datetime_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .elapsed_seconds_i (elapsed_seconds_i),
    .result_valid_i    (result_valid_o),
    .year_i            (year_o),
    .month_i           (month_o),
    .day_of_month_i    (day_of_month_o),
    .hour_i            (hour_o),
    .minute_i          (minute_o),
    .second_i          (second_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] at_day(int unsigned day, int unsigned secs);
    return 32'(day) * 32'd86400 + 32'(secs);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction is accepted.
  task automatic send_seconds(logic [31:0] value);
    start             <= 1'b1;
    elapsed_seconds_i <= value;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_seconds();
    int unsigned mode;
    int unsigned secs;
    logic [31:0] v;
    mode = $urandom_range(0, 9);
    if (mode <= 3) begin
      v = $urandom;
    end else if (mode <= 6) begin
      case ($urandom_range(0, 3))
        0:       secs = 0;
        1:       secs = 86399;
        2:       secs = $urandom_range(0, 59) + 60 * $urandom_range(0, 1439);
        default: secs = $urandom_range(0, 86399);
      endcase
      v = at_day($urandom_range(0, LastDay), secs);
    end else if (mode <= 8) begin
      v = $urandom_range(0, 40000000);
    end else begin
      v = 32'd1 << $urandom_range(0, 31);
      if ($urandom_range(0, 1)) v = ~v;
    end
    return v;
  endfunction

  initial begin
    logic [31:0] directed_q[$];
    int          sent;
    int          burst_len;
    int          gap;
    bit          no_gaps;

    rst_ni            = 1'b0;
    start             = 1'b0;
    elapsed_seconds_i = '0;
    directed_q = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                   at_day(1, 0), at_day(30, 86399), at_day(31, 0),
                   at_day(58, 86399), at_day(59, 0), at_day(364, 86399),
                   at_day(365, 0), at_day(1153, 86399), at_day(1154, 43199),
                   at_day(1155, 0), at_day(1460, 86399), at_day(1461, 0),
                   at_day(27451, 86399), at_day(27452, 0), at_day(27757, 86399),
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_q[i]) begin
      send_seconds(directed_q[i]);
    end

    sent = 0;
    while (sent < RandomCount) begin
      burst_len = $urandom_range(1, 24);
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len && sent < RandomCount; k++) begin
        send_seconds(random_seconds());
        sent++;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 8);
        if (k == burst_len - 1 && $urandom_range(0, 4) != 0) begin
          gap = ($urandom_range(0, 1)) ? $urandom_range(1, 40) : $urandom_range(41, 250);
        end
        if (gap > 0) begin
          start             <= 1'b0;
          elapsed_seconds_i <= $urandom;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
